/* src/pre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement engine package
// Shared state, command and status types and policy and register codes.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam logic [2:0] POL_FIFO   = 3'd0;
    localparam logic [2:0] POL_LRU    = 3'd1;
    localparam logic [2:0] POL_LFU    = 3'd2;
    localparam logic [2:0] POL_MFU    = 3'd3;
    localparam logic [2:0] POL_LFULRU = 3'd4;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;

    localparam int COUNT_BITS = 16;
    localparam int WORD_BITS  = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_LOOK,
        OP_HIT,
        OP_FILL,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_EVICT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic hit;
        logic full;
        logic by_count;
        logic scan_end;
        logic emit_end;
    } t_status;

endpackage

/* src/pre_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement controller
// Sequences lookup, victim scan, table update and per-frame result output.
// ----------------------------------------------------------------------------
module pre_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pre_pkg::t_status i_status,
    output pre_pkg::t_cmd    o_cmd,
    output logic             busy
);
    import pre_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_status.is_clear) begin
                    o_cmd.op = OP_CLEAR;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = OP_LOOK;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.hit) begin
                    o_cmd.op = OP_HIT;
                    n_state  = S_EMIT;
                end else if (!i_status.full) begin
                    o_cmd.op = OP_FILL;
                    n_state  = S_EMIT;
                end else if (i_status.by_count) begin
                    o_cmd.op = OP_SCAN_INIT;
                    n_state  = S_SCAN;
                end else begin
                    o_cmd.op = OP_EVICT;
                    n_state  = S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    o_cmd.op = OP_EVICT;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.op = OP_SCAN_STEP;
                end
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                if (i_status.emit_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* src/pre_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement datapath
// Ordered frame table, counters, configuration and result registers.
// ----------------------------------------------------------------------------
module pre_dp #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pre_pkg::t_cmd        i_cmd,
    output pre_pkg::t_status     o_status,
    input  logic                 i_kind,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_addr,
    input  logic [4:0]           i_cfg_data,
    output logic                 o_strobe,
    output logic [PAGE_BITS-1:0] o_frame_page,
    output logic                 o_frame_valid,
    output logic                 o_fault,
    output logic                 o_replaced,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [31:0]          o_fault_total,
    output logic [31:0]          o_replace_total,
    output logic                 o_last
);
    import pre_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int OW = $clog2(FRAMES + 1);
    localparam int LW = (OW > 5) ? OW : 5;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [WORD_BITS-1:0]  WRD_MAX = '1;

    logic [PAGE_BITS-1:0]  r_tag [FRAMES];
    logic [COUNT_BITS-1:0] r_cnt [FRAMES];
    logic [WORD_BITS-1:0]  r_stp [FRAMES];
    logic [PAGE_BITS-1:0]  n_tag [FRAMES];
    logic [COUNT_BITS-1:0] n_cnt [FRAMES];
    logic [WORD_BITS-1:0]  n_stp [FRAMES];

    logic [OW-1:0]         r_occ, n_occ;
    logic [WORD_BITS-1:0]  r_time, n_time;
    logic [WORD_BITS-1:0]  r_ftot, n_ftot;
    logic [WORD_BITS-1:0]  r_rtot, n_rtot;
    logic [2:0]            r_policy;
    logic [4:0]            r_frames;
    logic                  r_kind, n_kind;
    logic [PAGE_BITS-1:0]  r_page, n_page;
    logic                  r_hit, n_hit;
    logic [IW-1:0]         r_hidx, n_hidx;
    logic [IW-1:0]         r_vic, n_vic;
    logic [COUNT_BITS-1:0] r_bcnt, n_bcnt;
    logic [WORD_BITS-1:0]  r_bstp, n_bstp;
    logic [OW-1:0]         r_idx, n_idx;
    logic                  r_fault, n_fault;
    logic                  r_rep, n_rep;
    logic [PAGE_BITS-1:0]  r_evict, n_evict;

    logic                  r_o_strobe, n_o_strobe;
    logic [PAGE_BITS-1:0]  r_o_page, n_o_page;
    logic                  r_o_valid, n_o_valid;
    logic                  r_o_fault, n_o_fault;
    logic                  r_o_rep, n_o_rep;
    logic [PAGE_BITS-1:0]  r_o_evict, n_o_evict;
    logic [WORD_BITS-1:0]  r_o_ftot, n_o_ftot;
    logic [WORD_BITS-1:0]  r_o_rtot, n_o_rtot;
    logic                  r_o_last, n_o_last;

    logic [2:0]            pol;
    logic [LW-1:0]         limit;
    logic                  want_max;
    logic                  lk_hit;
    logic [IW-1:0]         lk_idx;
    logic [IW-1:0]         rd_idx;
    logic [IW-1:0]         top_idx;
    logic [IW-1:0]         shift_pos;
    logic                  better;
    logic [COUNT_BITS-1:0] hit_cnt;

    function automatic logic [WORD_BITS-1:0] sat_inc(input logic [WORD_BITS-1:0] v);
        return (v == WRD_MAX) ? v : v + 1'b1;
    endfunction

    // Out-of-range policy codes fall back to FIFO.
    assign pol      = (r_policy > POL_LFULRU) ? POL_FIFO : r_policy;
    assign want_max = (pol == POL_MFU);

    always_comb begin
        limit = LW'(r_frames);
        if (r_frames == 5'd0) begin
            limit = LW'(1);
        end else if (LW'(r_frames) > LW'(FRAMES)) begin
            limit = LW'(FRAMES);
        end
    end

    // Parallel tag compare; lowest matching entry wins.
    always_comb begin
        lk_hit = 1'b0;
        lk_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if ((OW'(i) < r_occ) && (r_tag[i] == r_page)) begin
                lk_hit = 1'b1;
                lk_idx = IW'(i);
            end
        end
    end

    assign rd_idx  = r_idx[IW-1:0];
    assign top_idx = IW'(r_occ - 1'b1);
    assign better  = want_max ? (r_cnt[rd_idx] > r_bcnt) : (r_cnt[rd_idx] < r_bcnt);
    assign hit_cnt = (r_cnt[r_hidx] == CNT_MAX) ? r_cnt[r_hidx] : r_cnt[r_hidx] + 1'b1;

    always_comb begin
        n_tag      = r_tag;
        n_cnt      = r_cnt;
        n_stp      = r_stp;
        n_occ      = r_occ;
        n_time     = r_time;
        n_ftot     = r_ftot;
        n_rtot     = r_rtot;
        n_kind     = r_kind;
        n_page     = r_page;
        n_hit      = r_hit;
        n_hidx     = r_hidx;
        n_vic      = r_vic;
        n_bcnt     = r_bcnt;
        n_bstp     = r_bstp;
        n_idx      = r_idx;
        n_fault    = r_fault;
        n_rep      = r_rep;
        n_evict    = r_evict;
        n_o_strobe = 1'b0;
        n_o_page   = r_o_page;
        n_o_valid  = r_o_valid;
        n_o_fault  = r_o_fault;
        n_o_rep    = r_o_rep;
        n_o_evict  = r_o_evict;
        n_o_ftot   = r_o_ftot;
        n_o_rtot   = r_o_rtot;
        n_o_last   = r_o_last;
        shift_pos  = (i_cmd.op == OP_HIT) ? r_hidx : r_vic;

        case (i_cmd.op)
            OP_LOAD: begin
                n_kind = i_kind;
                n_page = i_page;
            end
            OP_CLEAR: begin
                n_occ      = '0;
                n_time     = '0;
                n_ftot     = '0;
                n_rtot     = '0;
                n_o_strobe = 1'b1;
                n_o_page   = '0;
                n_o_valid  = 1'b0;
                n_o_fault  = 1'b0;
                n_o_rep    = 1'b0;
                n_o_evict  = '0;
                n_o_ftot   = '0;
                n_o_rtot   = '0;
                n_o_last   = 1'b1;
            end
            OP_LOOK: begin
                n_hit  = lk_hit;
                n_hidx = lk_idx;
                n_vic  = '0;
            end
            OP_HIT: begin
                if ((pol == POL_LRU) || (pol == POL_LFULRU)) begin
                    // Move the entry to the back with a fresh stamp.
                    for (int i = 0; i < FRAMES - 1; i++) begin
                        if ((IW'(i) >= shift_pos) && (OW'(i + 1) < r_occ)) begin
                            n_tag[i] = r_tag[i+1];
                            n_cnt[i] = r_cnt[i+1];
                            n_stp[i] = r_stp[i+1];
                        end
                    end
                    n_tag[top_idx] = r_page;
                    n_cnt[top_idx] = (pol == POL_LFULRU) ? hit_cnt : r_cnt[r_hidx];
                    n_stp[top_idx] = r_time;
                end else if ((pol == POL_LFU) || (pol == POL_MFU)) begin
                    n_cnt[r_hidx] = hit_cnt;
                end
                n_time  = sat_inc(r_time);
                n_idx   = r_occ - 1'b1;
                n_fault = 1'b0;
                n_rep   = 1'b0;
                n_evict = '0;
            end
            OP_FILL: begin
                n_tag[r_occ[IW-1:0]] = r_page;
                n_cnt[r_occ[IW-1:0]] = COUNT_BITS'(1);
                n_stp[r_occ[IW-1:0]] = r_time;
                n_occ   = r_occ + 1'b1;
                n_idx   = r_occ;
                n_time  = sat_inc(r_time);
                n_ftot  = sat_inc(r_ftot);
                n_fault = 1'b1;
                n_rep   = 1'b0;
                n_evict = '0;
            end
            OP_SCAN_INIT: begin
                n_vic  = '0;
                n_bcnt = r_cnt[0];
                n_bstp = r_stp[0];
                n_idx  = OW'(1);
            end
            OP_SCAN_STEP: begin
                if (better || ((r_cnt[rd_idx] == r_bcnt) && (r_stp[rd_idx] < r_bstp))) begin
                    n_vic  = rd_idx;
                    n_bcnt = r_cnt[rd_idx];
                    n_bstp = r_stp[rd_idx];
                end
                n_idx = r_idx + 1'b1;
            end
            OP_EVICT: begin
                // Drop the victim, close the gap, append the new page.
                for (int i = 0; i < FRAMES - 1; i++) begin
                    if ((IW'(i) >= shift_pos) && (OW'(i + 1) < r_occ)) begin
                        n_tag[i] = r_tag[i+1];
                        n_cnt[i] = r_cnt[i+1];
                        n_stp[i] = r_stp[i+1];
                    end
                end
                n_tag[top_idx] = r_page;
                n_cnt[top_idx] = COUNT_BITS'(1);
                n_stp[top_idx] = r_time;
                n_evict = r_tag[r_vic];
                n_idx   = r_occ - 1'b1;
                n_time  = sat_inc(r_time);
                n_ftot  = sat_inc(r_ftot);
                n_rtot  = sat_inc(r_rtot);
                n_fault = 1'b1;
                n_rep   = 1'b1;
            end
            OP_EMIT: begin
                n_o_strobe = 1'b1;
                n_o_page   = r_tag[rd_idx];
                n_o_valid  = 1'b1;
                n_o_fault  = r_fault;
                n_o_rep    = r_rep;
                n_o_evict  = r_evict;
                n_o_ftot   = r_ftot;
                n_o_rtot   = r_rtot;
                n_o_last   = (r_idx == '0);
                n_idx      = r_idx - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_time     <= '0;
            r_ftot     <= '0;
            r_rtot     <= '0;
            r_policy   <= POL_FIFO;
            r_frames   <= 5'd1;
            r_o_strobe <= 1'b0;
        end else begin
            r_occ      <= n_occ;
            r_time     <= n_time;
            r_ftot     <= n_ftot;
            r_rtot     <= n_rtot;
            r_o_strobe <= n_o_strobe;
            if (i_cfg_valid && (i_cfg_addr == CFG_POLICY)) begin
                r_policy <= i_cfg_data[2:0];
            end
            if (i_cfg_valid && (i_cfg_addr == CFG_FRAMES)) begin
                r_frames <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag     <= n_tag;
        r_cnt     <= n_cnt;
        r_stp     <= n_stp;
        r_kind    <= n_kind;
        r_page    <= n_page;
        r_hit     <= n_hit;
        r_hidx    <= n_hidx;
        r_vic     <= n_vic;
        r_bcnt    <= n_bcnt;
        r_bstp    <= n_bstp;
        r_idx     <= n_idx;
        r_fault   <= n_fault;
        r_rep     <= n_rep;
        r_evict   <= n_evict;
        r_o_page  <= n_o_page;
        r_o_valid <= n_o_valid;
        r_o_fault <= n_o_fault;
        r_o_rep   <= n_o_rep;
        r_o_evict <= n_o_evict;
        r_o_ftot  <= n_o_ftot;
        r_o_rtot  <= n_o_rtot;
        r_o_last  <= n_o_last;
    end

    assign o_status.is_clear = r_kind;
    assign o_status.hit      = r_hit;
    assign o_status.full     = (LW'(r_occ) >= limit);
    assign o_status.by_count = (pol == POL_LFU) || (pol == POL_MFU) || (pol == POL_LFULRU);
    assign o_status.scan_end = (r_idx >= r_occ);
    assign o_status.emit_end = (r_idx == '0);

    assign o_strobe        = r_o_strobe;
    assign o_frame_page    = r_o_page;
    assign o_frame_valid   = r_o_valid;
    assign o_fault         = r_o_fault;
    assign o_replaced      = r_o_rep;
    assign o_evicted_page  = r_o_evict;
    assign o_fault_total   = r_o_ftot;
    assign o_replace_total = r_o_rtot;
    assign o_last          = r_o_last;

endmodule

/* src/page_replacement_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement engine
// Each item is loaded and looked up; on a miss with a full table, count-based
// policies scan the occupied entries for a victim before the table update, then
// one result per resident frame follows, or one result for a clear. Start is
// ignored while busy. The receiver cannot stall. Synchronous active-low reset
// empties the table, zeroes time and totals, and sets policy FIFO with one
// usable frame.
module page_replacement_engine_core #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_kind,
    input  logic [PAGE_BITS-1:0] i_page,
    // configuration writes, always ready
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_addr,
    input  logic [4:0]           i_cfg_data,
    // results, one per strobe
    output logic                 o_strobe,
    output logic [PAGE_BITS-1:0] o_frame_page,
    output logic                 o_frame_valid,
    output logic                 o_fault,
    output logic                 o_replaced,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [31:0]          o_fault_total,
    output logic [31:0]          o_replace_total,
    output logic                 o_last
);
    import pre_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy;

    // Controller: walks lookup, optional victim scan, update, emit.
    pre_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (ctrl_busy)
    );

    // Datapath: frame table, counters, config registers, result registers.
    pre_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (i_kind),
        .i_page          (i_page),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_frame_page    (o_frame_page),
        .o_frame_valid   (o_frame_valid),
        .o_fault         (o_fault),
        .o_replaced      (o_replaced),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .o_replace_total (o_replace_total),
        .o_last          (o_last)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = 1'b1;

endmodule
